### hdl/sdse_pkg.sv
`timescale 1ns / 1ps
// Package: shared types, constants and expansion functions for the dot-stuffing encoder.
package sdse_pkg;

   localparam int QUEUE_DEPTH    = 4;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   // register index sits in paddr[2] (byte address 4*i)
   localparam logic CSR_IDX_CRLF_ALWAYS = 1'b0;

   localparam logic OP_DATA   = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_DOT = 8'h2E;
   localparam logic [7:0] CH_NUL = 8'h00;

   typedef struct packed {
      logic       opcode;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic       error;
   } rsp_type;

   typedef enum logic [2:0] {
      LS_START = 3'd0,
      LS_MID   = 3'd1,
      LS_CR    = 3'd2,
      LS_CRLF  = 3'd3,
      LS_DONE  = 3'd4
   } line_state_type;

   // what the back end has to send for one transaction
   typedef enum logic [2:0] {
      CK_BYTE   = 3'd0,  // the byte itself
      CK_DOT2   = 3'd1,  // stuffed dot
      CK_CRLF   = 3'd2,  // bare LF widened to CR LF
      CK_TERM_S = 3'd3,  // . CR LF
      CK_TERM_L = 3'd4,  // CR LF . CR LF
      CK_ERR    = 3'd5   // data after finish
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_push_type;

   typedef struct packed {
      logic    empty;
      cmd_type cmd;
   } cmd_head_type;

   function automatic logic [2:0] cmd_len(input cmd_kind_type kind);
      logic [2:0] n;
      case (kind)
         CK_DOT2:   n = 3'd2;
         CK_CRLF:   n = 3'd2;
         CK_TERM_S: n = 3'd3;
         CK_TERM_L: n = 3'd5;
         default:   n = 3'd1;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] cmd_byte(input cmd_kind_type kind, input logic [2:0] idx,
                                           input logic [7:0] data);
      logic [7:0] b;
      case (kind)
         CK_BYTE: b = data;
         CK_DOT2: b = CH_DOT;
         CK_CRLF: b = (idx == 3'd0) ? CH_CR : CH_LF;
         CK_TERM_S: begin
            case (idx)
               3'd0:    b = CH_DOT;
               3'd1:    b = CH_CR;
               default: b = CH_LF;
            endcase
         end
         CK_TERM_L: begin
            case (idx)
               3'd0:    b = CH_CR;
               3'd1:    b = CH_LF;
               3'd2:    b = CH_DOT;
               3'd3:    b = CH_CR;
               default: b = CH_LF;
            endcase
         end
         default: b = CH_NUL;
      endcase
      return b;
   endfunction

endpackage

### hdl/sdse_front.sv
`timescale 1ns / 1ps
// Front end: accepts input transactions, tracks line state, classifies each into a command.
module sdse_front
   import sdse_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  req_type      req_item,
   input  logic         crlf_always,
   output cmd_push_type push_out
);

   line_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      if (accept) begin
         case (state_ff)
            LS_START, LS_MID, LS_CR, LS_CRLF: begin
               if (req_item.opcode == OP_FINISH) begin
                  state_in = LS_DONE;
               end else if (req_item.data_byte == CH_LF) begin
                  state_in = LS_CRLF;
               end else if (req_item.data_byte == CH_CR) begin
                  state_in = LS_CR;
               end else begin
                  state_in = LS_MID;
               end
            end
            default: state_in = LS_DONE;
         endcase
      end
   end

   always_comb begin
      push_out.valid    = accept;
      push_out.cmd.kind = CK_BYTE;
      push_out.cmd.data = req_item.data_byte;
      case (state_ff)
         LS_START, LS_MID, LS_CR, LS_CRLF: begin
            if (req_item.opcode == OP_FINISH) begin
               push_out.cmd.kind = (state_ff == LS_CRLF && !crlf_always) ?
                                   CK_TERM_S : CK_TERM_L;
            end else if (req_item.data_byte == CH_LF) begin
               push_out.cmd.kind = (state_ff == LS_CR) ? CK_BYTE : CK_CRLF;
            end else if (req_item.data_byte == CH_DOT &&
                         (state_ff == LS_START || state_ff == LS_CRLF)) begin
               push_out.cmd.kind = CK_DOT2;
            end
         end
         default: begin
            // finished: data is flagged, a repeated finish sends nothing
            push_out.cmd.kind = CK_ERR;
            push_out.valid    = accept && (req_item.opcode == OP_DATA);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LS_START;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hdl/sdse_queue.sv
`timescale 1ns / 1ps
// Command queue between front and back end.
module sdse_queue
   import sdse_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  cmd_push_type push_in,
   output logic         full,
   input  logic         pop,
   output cmd_head_type head
);

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);
   localparam logic [CntWidth-1:0] FullCnt = CntWidth'(Depth);

   cmd_type               slot_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign full       = (count_ff == FullCnt);
   assign head.empty = (count_ff == '0);
   assign head.cmd   = slot_ff[rd_ptr_ff];

   assign do_push = push_in.valid && !full;
   assign do_pop  = pop && !head.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_in.cmd;
      end
   end

endmodule

### hdl/sdse_back.sv
`timescale 1ns / 1ps
// Back end: expands queued commands into the output register, a byte per cycle unless stalled.
module sdse_back
   import sdse_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cmd_head_type head,
   output logic         head_pop,
   output logic         empty,
   input  logic         pop,
   output rsp_type      rsp_item
);

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   rsp_type    out_ff, out_in;
   logic       emit, is_last;

   // output register free this cycle, or being drained
   assign emit     = !head.empty && (!valid_ff || pop);
   assign is_last  = (idx_ff == cmd_len(head.cmd.kind) - 3'd1);
   assign head_pop = emit && is_last;
   assign empty    = !valid_ff;
   assign rsp_item = out_ff;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && !pop;
      out_in   = out_ff;
      if (emit) begin
         valid_in        = 1'b1;
         out_in.out_byte = cmd_byte(head.cmd.kind, idx_ff, head.cmd.data);
         out_in.last     = is_last;
         out_in.error    = (head.cmd.kind == CK_ERR);
         idx_in          = is_last ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule

### hdl/smtp_dot_stuffing_encoder.sv
`timescale 1ns / 1ps
// Top level: dot-stuffing encoder with CSR port, front end, command queue and back end.
//
//   channel   direction  handshake                       payload
//   request   in         push / full                     req_item (req_type)
//   response  out        empty / pop                     rsp_item (rsp_type)
//   csr       in/out     psel penable pwrite pready      paddr pwdata prdata
//
// The back end sends one byte per cycle while the output register is free or popped; an item yields
// one byte for a plain byte, two for a stuffed dot or widened LF, and three or five on finish,
// so a plain byte stream runs at one item per cycle while the output keeps being popped.
// The front end classifies in the accept cycle and runs ahead through the command queue.
// Reset clears line state, queue, output valid flag and the CSR.
// A pop held low stalls only the back end; full rises once the queue has filled.
module smtp_dot_stuffing_encoder
   import sdse_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  req_type                   req_item,
   output logic                      empty,
   input  logic                      pop,
   output rsp_type                   rsp_item,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   logic         force_ff, force_in;
   logic         csr_hit;
   logic         accept;
   logic         head_pop;
   cmd_push_type push_cmd;
   cmd_head_type head;

   assign pready  = 1'b1;
   assign csr_hit = (paddr[2] == CSR_IDX_CRLF_ALWAYS);
   assign prdata  = csr_hit ? {{(CSR_DATA_WIDTH-1){1'b0}}, force_ff} : '0;

   always_comb begin
      force_in = force_ff;
      if (psel && penable && pwrite && pready && csr_hit) begin
         force_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         force_ff <= 1'b0;
      end else begin
         force_ff <= force_in;
      end
   end

   assign accept = push && !full;

   sdse_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_item    (req_item),
      .crlf_always (force_ff),
      .push_out    (push_cmd)
   );

   sdse_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (push_cmd),
      .full    (full),
      .pop     (head_pop),
      .head    (head)
   );

   sdse_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .head_pop (head_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

endmodule
